FILE: design/karplus_strong_string_voice_core_macros.svh
// Assertion macros for the plucked-string voice core.
// Included by the RTL files that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef KARPLUS_STRONG_STRING_VOICE_CORE_MACROS_SVH
`define KARPLUS_STRONG_STRING_VOICE_CORE_MACROS_SVH

`ifndef SYNTH

`define KSV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define KSV_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define KSV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define KSV_ASSERT(lbl, prop, msg)

`define KSV_ASSERT_IMPL(lbl, ante, cons, msg)

`define KSV_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: design/ksv_pkg.sv
// Shared types, widths and constants for the plucked-string voice core.
// No dependencies; imported by every module of the block except the generic ksv_ram.
`timescale 1ns / 1ps

package ksv_pkg;

  // String store geometry
  localparam int BufDepth = 1024;
  localparam int AddrW    = $clog2(BufDepth);
  localparam int LenW     = $clog2(BufDepth + 1);

  // Field and register widths
  localparam int PeriodW  = 11;
  localparam int DurW     = 20;
  localparam int DecayW   = 16;
  localparam int GainW    = 7;
  localparam int SampleW  = 15;
  localparam int EntryW   = 15;
  localparam int LevelW   = 8;
  localparam int LfsrW    = 16;
  localparam int ProdW    = LevelW + GainW;
  localparam int SumW     = EntryW + 1;
  localparam int FiltW    = DecayW + SumW;
  localparam int DecayShift = 17;

  // Minimum loop length
  localparam int MinLen   = 2;

  // Noise source
  localparam logic [LfsrW-1:0] LfsrSeed = 16'hACE1;
  localparam logic [LfsrW-1:0] LfsrTaps = 16'hB400;

  // Output ceiling
  localparam logic [SampleW-1:0] SampleMax = 15'h7FFF;

  // Register reset values
  localparam logic [DurW-1:0]   NoteDurationRst = 20'd144000;
  localparam logic [DecayW-1:0] DecayGainRst    = 16'd65470;
  localparam logic [GainW-1:0]  OutputGainRst   = 7'd30;

  // Configuration port
  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 32;
  localparam int RegIdxW  = 2;
  localparam logic [RegIdxW-1:0] RegNoteDuration = 2'd0;
  localparam logic [RegIdxW-1:0] RegDecayGain    = 2'd1;
  localparam logic [RegIdxW-1:0] RegOutputGain   = 2'd2;

  // Request commands
  localparam logic CmdTick  = 1'b0;
  localparam logic CmdPluck = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [PeriodW-1:0] period_length;
  } ksv_in_t;

  typedef struct packed {
    logic [SampleW-1:0] sample_out;
    logic               playing;
  } ksv_out_t;

  typedef struct packed {
    logic [DurW-1:0]   note_duration;
    logic [DecayW-1:0] decay_gain;
    logic [GainW-1:0]  output_gain;
  } ksv_cfg_t;

  typedef enum logic [2:0] {
    KSV_IDLE,
    KSV_FILL,
    KSV_READ_NXT,
    KSV_MULT,
    KSV_EMIT
  } ksv_state_e;

endpackage

FILE: design/ksv_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; used for the string store.
`timescale 1ns / 1ps

module ksv_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/ksv_noise.sv
// Galois LFSR noise source for string excitation.
// Depends on ksv_pkg for seed, taps and widths.
`timescale 1ns / 1ps

module ksv_noise
  import ksv_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  output logic [EntryW-1:0] noise_o
);

  logic [LfsrW-1:0] lfsr_q;
  logic [LfsrW-1:0] lfsr_d;

  // Shift right, fold taps in when the bit leaving is set
  always_comb begin
    lfsr_d = lfsr_q >> 1;
    if (lfsr_q[0]) begin
      lfsr_d = lfsr_d ^ LfsrTaps;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= LfsrSeed;
    end else if (step_i) begin
      lfsr_q <= lfsr_d;
    end
  end

  // The stored entry takes the stepped value
  assign noise_o = lfsr_d[EntryW-1:0];

endmodule

FILE: design/ksv_regs.sv
// APB-style configuration registers: note duration, loop decay, output gain.
// Depends on ksv_pkg for register codes, reset values and the config struct.
`timescale 1ns / 1ps

module ksv_regs
  import ksv_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output ksv_cfg_t            cfg_o
);

  ksv_cfg_t           cfg_q;
  logic               wr_en;
  logic [RegIdxW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[CfgAddrW-1:CfgAddrW-RegIdxW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.note_duration <= NoteDurationRst;
      cfg_q.decay_gain    <= DecayGainRst;
      cfg_q.output_gain   <= OutputGainRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegNoteDuration: cfg_q.note_duration <= pwdata[DurW-1:0];
        RegDecayGain:    cfg_q.decay_gain    <= pwdata[DecayW-1:0];
        RegOutputGain:   cfg_q.output_gain   <= pwdata[GainW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegNoteDuration: prdata = CfgDataW'(cfg_q.note_duration);
      RegDecayGain:    prdata = CfgDataW'(cfg_q.decay_gain);
      RegOutputGain:   prdata = CfgDataW'(cfg_q.output_gain);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/karplus_strong_string_voice_core.sv
// Plucked-string voice: request sequencer around the string store memory.
// Depends on ksv_pkg, ksv_ram, ksv_noise, ksv_regs and the assertion macros header.
`timescale 1ns / 1ps

`include "karplus_strong_string_voice_core_macros.svh"

// Karplus-Strong plucked-string voice. A pluck request (cmd = 1) clamps
// period_length to [2, BufDepth], fills that many string store entries with
// LFSR noise from the top entry down, rewinds the read position, loads the
// note duration and starts the note; it returns no result. A tick request
// (cmd = 0) returns one result: while sounding it reads the current and next
// entries, writes back decay_gain * (cur + next) >> 17, takes level = cur >> 7
// and counts the duration down; when silent it repeats the last level.
// sample_out = level * output_gain. A sounding tick steps through READ_NXT,
// MULT and EMIT, set by the single read port of the string memory (current
// entry read at the accept, next in READ_NXT) and then the registered decay
// multiply and the write-back; a silent tick goes straight to EMIT; EMIT waits
// on a stall; a pluck writes one noise entry per cycle. Because one request runs to
// completion before the next is taken, a write-back always lands before the
// next read of the same entry. The string store has no reset or clearing
// pass; only entries written by the last pluck are ever read. A finished
// result waits in the output register while the next request is accepted.
module karplus_strong_string_voice_core
  import ksv_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ksv_in_t             in_data_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ksv_out_t            out_data_o,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  ksv_cfg_t cfg;

  ksv_state_e state_q, state_d;

  // voice state
  logic [AddrW-1:0]  pos_q;
  logic [LenW-1:0]   loop_len_q;
  logic [DurW-1:0]   rem_q;
  logic              active_q;
  logic [LevelW-1:0] level_q;
  logic [AddrW-1:0]  fill_addr_q;
  logic              played_q;

  // datapath payload
  logic [EntryW-1:0] cur_q;
  logic [EntryW-1:0] filt_q;
  logic              out_valid_q;
  ksv_out_t          out_data_q;

  // memory and noise hookup
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [EntryW-1:0] ram_wdata;
  logic [AddrW-1:0]  ram_raddr;
  logic [EntryW-1:0] ram_rdata;
  logic              noise_step;
  logic [EntryW-1:0] noise;

  // combinational helpers
  logic              in_fire;
  logic              emit_go;
  logic [LenW-1:0]   len_clamp;
  logic [LenW-1:0]   pos_plus;
  logic [AddrW-1:0]  nxt;
  logic [SumW-1:0]   loop_sum;
  logic [FiltW-1:0]  filt_full;
  logic [DurW-1:0]   rem_after;
  logic [LevelW-1:0] level_now;
  logic [ProdW-1:0]  gain_prod;
  logic [SampleW-1:0] sample;

  ksv_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ksv_noise u_noise (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (noise_step),
    .noise_o (noise)
  );

  ksv_ram #(
    .Width (EntryW),
    .Depth (BufDepth)
  ) u_string_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_fire = in_valid_i & ~in_stall_o;
  // Finish a tick once the output register is free or being drained
  assign emit_go = (state_q == KSV_EMIT) & (~out_valid_q | ~out_stall_i);

  // Clamp the requested loop length into the store
  always_comb begin
    if (32'(in_data_i.period_length) > BufDepth) begin
      len_clamp = LenW'(BufDepth);
    end else if (32'(in_data_i.period_length) < MinLen) begin
      len_clamp = LenW'(MinLen);
    end else begin
      len_clamp = LenW'(in_data_i.period_length);
    end
  end

  // Circular advance of the read position
  assign pos_plus = LenW'(pos_q) + LenW'(1);
  assign nxt      = (pos_plus >= loop_len_q) ? '0 : AddrW'(pos_plus);

  // Loop filter: averaged pair scaled by the decay gain, back to Q15
  assign loop_sum  = SumW'(cur_q) + SumW'(ram_rdata);
  assign filt_full = FiltW'(cfg.decay_gain) * FiltW'(loop_sum);

  assign rem_after = (rem_q == '0) ? '0 : rem_q - DurW'(1);

  // Output level: fresh from the string when sounding, held otherwise
  assign level_now = played_q ? cur_q[EntryW-1 -: LevelW] : level_q;
  assign gain_prod = ProdW'(level_now) * ProdW'(cfg.output_gain);
  assign sample    = (gain_prod > ProdW'(SampleMax)) ? SampleMax : SampleW'(gain_prod);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      KSV_IDLE: begin
        if (in_fire) begin
          if (in_data_i.cmd == CmdPluck) begin
            state_d = KSV_FILL;
          end else if (active_q) begin
            state_d = KSV_READ_NXT;
          end else begin
            state_d = KSV_EMIT;
          end
        end
      end
      KSV_FILL: begin
        if (fill_addr_q == '0) begin
          state_d = KSV_IDLE;
        end
      end
      KSV_READ_NXT: state_d = KSV_MULT;
      KSV_MULT:     state_d = KSV_EMIT;
      KSV_EMIT: begin
        if (emit_go) begin
          state_d = KSV_IDLE;
        end
      end
      default: state_d = KSV_IDLE;
    endcase
  end

  // Sequencer outputs: memory port, noise step, request stall
  always_comb begin
    in_stall_o = 1'b1;
    ram_we     = 1'b0;
    ram_waddr  = pos_q;
    ram_wdata  = filt_q;
    ram_raddr  = pos_q;
    noise_step = 1'b0;
    unique case (state_q)
      KSV_IDLE: begin
        // present the current entry address so it reads out during the accept
        in_stall_o = 1'b0;
      end
      KSV_FILL: begin
        ram_we     = 1'b1;
        ram_waddr  = fill_addr_q;
        ram_wdata  = noise;
        noise_step = 1'b1;
      end
      KSV_READ_NXT: begin
        ram_raddr = nxt;
      end
      KSV_MULT: ;
      KSV_EMIT: begin
        ram_we = played_q & emit_go;
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= KSV_IDLE;
      pos_q       <= '0;
      loop_len_q  <= '0;
      rem_q       <= '0;
      active_q    <= 1'b0;
      level_q     <= '0;
      fill_addr_q <= '0;
      played_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (state_q == KSV_IDLE && in_fire) begin
        if (in_data_i.cmd == CmdPluck) begin
          // restart the note
          loop_len_q  <= len_clamp;
          pos_q       <= '0;
          rem_q       <= cfg.note_duration;
          active_q    <= 1'b1;
          level_q     <= '0;
          fill_addr_q <= AddrW'(len_clamp - LenW'(1));
        end else begin
          played_q <= active_q;
        end
      end

      if (state_q == KSV_FILL) begin
        fill_addr_q <= fill_addr_q - AddrW'(1);
      end

      if (emit_go && played_q) begin
        pos_q    <= nxt;
        rem_q    <= rem_after;
        active_q <= (rem_after != '0);
        level_q  <= level_now;
      end

      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == KSV_READ_NXT) begin
      cur_q <= ram_rdata;
    end
    if (state_q == KSV_MULT) begin
      filt_q <= filt_full[DecayShift +: EntryW];
    end
    if (emit_go) begin
      out_data_q.sample_out <= sample;
      out_data_q.playing    <= played_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `KSV_ASSERT_NEXT(a_fill_ends, state_q == KSV_FILL && fill_addr_q == '0, state_q == KSV_IDLE, "fill did not end at entry zero")
  `KSV_ASSERT_IMPL(a_pos_in_loop, active_q, LenW'(pos_q) < loop_len_q && loop_len_q >= LenW'(MinLen), "read position outside the loop")
  `KSV_ASSERT_IMPL(a_we_source, ram_we, state_q == KSV_FILL || (state_q == KSV_EMIT && played_q), "string store written outside fill or write-back")
  `KSV_ASSERT_IMPL(a_out_from_emit, $rose(out_valid_q), $past(state_q) == KSV_EMIT, "result raised without a finished tick")
  `KSV_ASSERT(a_pluck_no_result, !(state_q == KSV_FILL && emit_go), "pluck produced a result")

endmodule
